// ----- sv/mutq_pkg.sv -----
// Shared types and constants for the MIDI UART transmit queue.
package mutq_pkg;

	localparam int QUEUE_DEPTH = 256;
	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [5:0] BUDGET_MAX   = 6'd32;
	localparam logic [5:0] BUDGET_RESET = 6'd32;
	localparam logic [7:0] CMD_RESET    = 8'hFF;
	localparam logic [7:0] CMD_UART     = 8'h3F;
	localparam logic [7:0] CTRL_CHANGE  = 8'hB0;
	localparam logic [7:0] CTRL_ALL_OFF = 8'd123;
	localparam logic [3:0] LAST_CHANNEL = 4'd15;

	typedef enum logic [2:0] {
		ACT_SEND     = 3'd0,
		ACT_FLUSH    = 3'd1,
		ACT_ALL_OFF  = 3'd2,
		ACT_DETECT   = 3'd3,
		ACT_INIT     = 3'd4,
		ACT_SHUTDOWN = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		PH_STATUS = 2'd0,
		PH_CTRL   = 2'd1,
		PH_VALUE  = 2'd2
	} ano_phase_t;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_DISPATCH = 3'd1,
		ST_FLUSH    = 3'd2,
		ST_ALL_OFF  = 3'd3,
		ST_DETECT2  = 3'd4
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic send;
		logic status;
		logic pop;
		logic ano;
		logic det_first;
		logic det_second;
		logic clr_ready;
		logic last;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		action_t action;
		logic    ready;
		logic    more;
		logic    more_next;
		logic    ano_last;
	} status_t;

endpackage

// ----- sv/mutq_ctrl.sv -----
// Controller state machine of the MIDI UART transmit queue.
module mutq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mutq_pkg::status_t sts,
	output mutq_pkg::cmd_t    cmd,
	output logic              busy
);
	import mutq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		busy = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				state_d = ST_IDLE;
				unique case (sts.action)
					ACT_SEND: begin
						cmd.send = 1'b1;
						cmd.last = 1'b1;
					end
					ACT_FLUSH: begin
						if (sts.more) begin
							state_d = ST_FLUSH;
						end else begin
							cmd.status = 1'b1;
							cmd.last = 1'b1;
						end
					end
					ACT_ALL_OFF: begin
						state_d = ST_ALL_OFF;
					end
					ACT_DETECT: begin
						cmd.det_first = 1'b1;
						state_d = ST_DETECT2;
					end
					ACT_INIT: begin
						if (sts.ready) begin
							cmd.status = 1'b1;
							cmd.last = 1'b1;
						end else begin
							cmd.det_first = 1'b1;
							state_d = ST_DETECT2;
						end
					end
					ACT_SHUTDOWN: begin
						cmd.clr_ready = 1'b1;
						cmd.status = 1'b1;
						cmd.last = 1'b1;
					end
					default: begin
						cmd.status = 1'b1;
						cmd.last = 1'b1;
					end
				endcase
			end
			ST_FLUSH: begin
				cmd.pop = 1'b1;
				cmd.last = !sts.more_next;
				if (!sts.more_next) begin
					state_d = ST_IDLE;
				end
			end
			ST_ALL_OFF: begin
				cmd.ano = 1'b1;
				cmd.last = sts.ano_last;
				if (sts.ano_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_DETECT2: begin
				cmd.det_second = 1'b1;
				cmd.last = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/mutq_datapath.sv -----
// Datapath of the MIDI UART transmit queue: ring memory, pointers, counters, result register.
module mutq_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  mutq_pkg::cmd_t    cmd,
	output mutq_pkg::status_t sts,
	input  logic [2:0]        action,
	input  logic [7:0]        data_byte,
	input  logic [5:0]        device_room,
	input  logic              cfg_we,
	input  logic [5:0]        cfg_data,
	output logic              strobe,
	output logic              byte_valid,
	output logic              port_select,
	output logic [7:0]        out_byte,
	output logic              last_of_run,
	output logic              dropped,
	output logic              ready_flag,
	output logic [7:0]        queue_count,
	output logic [31:0]       bytes_sent_total
);
	import mutq_pkg::*;

	function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [7:0] fill_sat(input logic [PTR_W-1:0] wr,
			input logic [PTR_W-1:0] rd);
		logic [PTR_W:0] cnt;
		if (wr >= rd) begin
			cnt = {1'b0, wr} - {1'b0, rd};
		end else begin
			cnt = {1'b0, wr} + (PTR_W + 1)'(QUEUE_DEPTH) - {1'b0, rd};
		end
		return (32'(cnt) > 32'd255) ? 8'hFF : 8'(cnt);
	endfunction

	logic [7:0]       queue_mem [QUEUE_DEPTH];
	logic [7:0]       rd_data_q;
	logic [PTR_W-1:0] rd_q, wr_q, rd_d, wr_d;
	logic             ready_q, ready_d;
	logic [31:0]      sent_q, sent_d;
	logic [5:0]       budget_q;
	action_t          action_q;
	logic [7:0]       data_q;
	logic [5:0]       lim_q, i_q;
	logic [3:0]       ch_q;
	ano_phase_t       phase_q;
	logic             we, drop, emit;
	logic [5:0]       budget_sat, lim_d;
	logic [7:0]       byte_d;

	always_comb begin
		budget_sat = (budget_q > BUDGET_MAX) ? BUDGET_MAX : budget_q;
		lim_d = (device_room < budget_sat) ? device_room : budget_sat;
	end

	// Next values of the architectural state for the current command.
	always_comb begin
		rd_d = rd_q;
		wr_d = wr_q;
		ready_d = ready_q;
		sent_d = sent_q;
		we = 1'b0;
		drop = 1'b0;
		if (cmd.send) begin
			if (wrap_next(wr_q) != rd_q) begin
				we = 1'b1;
				wr_d = wrap_next(wr_q);
			end else begin
				drop = 1'b1;
			end
		end
		if (cmd.pop) begin
			rd_d = wrap_next(rd_q);
			sent_d = sent_q + 32'd1;
		end
		if (cmd.det_first) begin
			rd_d = '0;
			wr_d = '0;
			ready_d = 1'b1;
		end
		if (cmd.clr_ready) begin
			ready_d = 1'b0;
		end
	end

	always_comb begin
		emit = cmd.send | cmd.status | cmd.pop | cmd.ano | cmd.det_first | cmd.det_second;
		byte_d = 8'h00;
		priority if (cmd.pop) begin
			byte_d = rd_data_q;
		end else if (cmd.ano) begin
			unique case (phase_q)
				PH_STATUS: byte_d = CTRL_CHANGE | {4'h0, ch_q};
				PH_CTRL:   byte_d = CTRL_ALL_OFF;
				default:   byte_d = 8'h00;
			endcase
		end else if (cmd.det_first) begin
			byte_d = CMD_RESET;
		end else if (cmd.det_second) begin
			byte_d = CMD_UART;
		end else begin
			byte_d = 8'h00;
		end
	end

	always_comb begin
		sts.action = action_q;
		sts.ready = ready_q;
		sts.more = (i_q < lim_q) && (rd_q != wr_q);
		sts.more_next = ((i_q + 6'd1) < lim_q) && (wrap_next(rd_q) != wr_q);
		sts.ano_last = (ch_q == LAST_CHANNEL) && (phase_q == PH_VALUE);
	end

	always_ff @(posedge clk) begin
		if (we) begin
			queue_mem[wr_q] <= data_q;
		end
		rd_data_q <= queue_mem[rd_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			ready_q <= 1'b0;
			sent_q <= '0;
			budget_q <= BUDGET_RESET;
			strobe <= 1'b0;
		end else begin
			rd_q <= rd_d;
			wr_q <= wr_d;
			ready_q <= ready_d;
			sent_q <= sent_d;
			if (cfg_we) begin
				budget_q <= cfg_data;
			end
			strobe <= emit;
		end
	end

	// Item registers and the result register carry payload only.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			action_q <= action_t'(action);
			data_q <= data_byte;
			lim_q <= lim_d;
			i_q <= '0;
			ch_q <= '0;
			phase_q <= PH_STATUS;
		end else begin
			if (cmd.pop) begin
				i_q <= i_q + 6'd1;
			end
			if (cmd.ano) begin
				if (phase_q == PH_VALUE) begin
					phase_q <= PH_STATUS;
					ch_q <= ch_q + 4'd1;
				end else if (phase_q == PH_STATUS) begin
					phase_q <= PH_CTRL;
				end else begin
					phase_q <= PH_VALUE;
				end
			end
		end
		if (emit) begin
			byte_valid <= cmd.pop | cmd.ano | cmd.det_first | cmd.det_second;
			port_select <= cmd.det_first | cmd.det_second;
			out_byte <= byte_d;
			last_of_run <= cmd.last;
			dropped <= drop;
			ready_flag <= ready_d;
			queue_count <= fill_sat(wr_d, rd_d);
			bytes_sent_total <= sent_d;
		end
	end

endmodule

// ----- sv/midi_uart_transmit_queue.sv -----
// Top level of the MIDI UART transmit queue: controller, datapath and checks.
// The first result of an item is registered from its dispatch step; for a flush that sends
// bytes and for all-notes-off (48 results) it is registered from the first flush or
// all-notes-off step. A new item is taken only while idle, after every step of the last one.
// Results cannot be stalled.
// Reset clears pointers, ready state, sent count and strobe and sets the budget to 32, not RAM.
module midi_uart_transmit_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  action,
	input  logic [7:0]  data_byte,
	input  logic [5:0]  device_room,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data,
	output logic        strobe,
	output logic        byte_valid,
	output logic        port_select,
	output logic [7:0]  out_byte,
	output logic        last_of_run,
	output logic        dropped,
	output logic        ready_flag,
	output logic [7:0]  queue_count,
	output logic [31:0] bytes_sent_total
);
	import mutq_pkg::*;

	cmd_t    cmd;
	status_t sts;

	// The budget register is writable in any cycle; the user must issue writes only while idle.
	assign cfg_ready = 1'b1;

	// The controller sequences each item; one command per cycle drives the datapath.
	mutq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	// The datapath owns the queue memory, the pointers, the counters and the
	// registered result ports, so every result is shown for one cycle only.
	mutq_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.action           (action),
		.data_byte        (data_byte),
		.device_room      (device_room),
		.cfg_we           (cfg_valid & cfg_ready),
		.cfg_data         (cfg_data),
		.strobe           (strobe),
		.byte_valid       (byte_valid),
		.port_select      (port_select),
		.out_byte         (out_byte),
		.last_of_run      (last_of_run),
		.dropped          (dropped),
		.ready_flag       (ready_flag),
		.queue_count      (queue_count),
		.bytes_sent_total (bytes_sent_total)
	);

	// After the final transfer of an item the controller is idle, so no result follows.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_of_run |=> !strobe)
		else $error("result transfer directly after the last one of an item");

	// An accepted item always keeps the block busy in the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting an item");

	// A result without a byte is always the only result of its item.
	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !byte_valid |-> last_of_run)
		else $error("status result not marked last");

	// Command-port writes always carry a byte, and dropped sends never do.
	a_flags_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> (!port_select || byte_valid) && !(dropped && byte_valid))
		else $error("inconsistent byte flags on a result");

endmodule

// ----- sim/tb_midi_uart_transmit_queue.sv -----
// Self-checking testbench for the MIDI UART transmit queue: directed table, then random phases.
module tb_midi_uart_transmit_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import mutq_pkg::*;

	// Action codes 6 and 7 are not defined; the block must answer them with a status result.
	localparam logic [2:0] ACT_RSVD_A = 3'd6;
	localparam logic [2:0] ACT_RSVD_B = 3'd7;

	// Cycles without any transfer (item, result or register write) before the run is abandoned.
	// The longest quiet stretch of a correct run is the final drain wait, far inside this limit.
	localparam int WATCHDOG_LIMIT = 2000;

	// All-notes-off keeps the block busy longest after its last acceptance.
	localparam int DRAIN_CYCLES = 60;

	// One result as it appears on the ports, in port order.
	typedef struct packed {
		logic        byte_valid;
		logic        port_select;
		logic [7:0]  out_byte;
		logic        last_of_run;
		logic        dropped;
		logic        ready_flag;
		logic [7:0]  queue_count;
		logic [31:0] bytes_sent_total;
	} port_result_t;

	// One row of the directed table. Where typed is set, the first result of the item is the
	// one written in the row; every other result comes from the queue model below.
	typedef struct packed {
		logic [2:0]   act;
		logic [7:0]   data;
		logic [5:0]   room;
		logic         typed;
		port_result_t first;
	} stim_row_t;

	typedef enum logic [1:0] {
		MODE_MIX,
		MODE_FILL,
		MODE_DRAIN
	} stim_mode_t;

	localparam port_result_t UNTYPED = '0;
	localparam int DIRECTED_ROWS = 24;

	// The directed table. The first rows start from reset, where the answer is plain: status
	// results with nothing queued, then init bringing the port up, then the first two sends.
	// After that the rows cover room of zero, one and above the budget, a drain to empty,
	// all-notes-off, a send while shut down, and detect clearing a partly full queue without
	// touching the sent count.
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{ACT_SHUTDOWN, 8'h00, 6'd0,  1'b1,
			'{1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 8'd0, 32'd0}},
		'{ACT_FLUSH,    8'h00, 6'd32, 1'b1,
			'{1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 8'd0, 32'd0}},
		'{ACT_RSVD_B,   8'h00, 6'd0,  1'b1,
			'{1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 8'd0, 32'd0}},
		'{ACT_RSVD_A,   8'hFF, 6'd63, 1'b1,
			'{1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b0, 8'd0, 32'd0}},
		'{ACT_INIT,     8'h00, 6'd0,  1'b1,
			'{1'b1, 1'b1, CMD_RESET, 1'b0, 1'b0, 1'b1, 8'd0, 32'd0}},
		'{ACT_INIT,     8'h00, 6'd0,  1'b1,
			'{1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 8'd0, 32'd0}},
		'{ACT_SEND,     8'h00, 6'd0,  1'b1,
			'{1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 8'd1, 32'd0}},
		'{ACT_SEND,     8'hFF, 6'd63, 1'b1,
			'{1'b0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1, 8'd2, 32'd0}},
		'{ACT_SEND,     8'h55, 6'd21, 1'b0, UNTYPED},
		'{ACT_SEND,     8'hAA, 6'd42, 1'b0, UNTYPED},
		'{ACT_FLUSH,    8'h00, 6'd0,  1'b0, UNTYPED},
		'{ACT_FLUSH,    8'h00, 6'd1,  1'b0, UNTYPED},
		'{ACT_FLUSH,    8'h00, 6'd63, 1'b0, UNTYPED},
		'{ACT_ALL_OFF,  8'h00, 6'd0,  1'b0, UNTYPED},
		'{ACT_SHUTDOWN, 8'h00, 6'd0,  1'b0, UNTYPED},
		'{ACT_SEND,     8'h81, 6'd0,  1'b0, UNTYPED},
		'{ACT_DETECT,   8'h00, 6'd0,  1'b0, UNTYPED},
		'{ACT_SEND,     8'h12, 6'd0,  1'b0, UNTYPED},
		'{ACT_SEND,     8'h34, 6'd0,  1'b0, UNTYPED},
		'{ACT_SEND,     8'h56, 6'd0,  1'b0, UNTYPED},
		'{ACT_FLUSH,    8'h00, 6'd2,  1'b0, UNTYPED},
		'{ACT_DETECT,   8'h00, 6'd0,  1'b0, UNTYPED},
		'{ACT_FLUSH,    8'h00, 6'd32, 1'b0, UNTYPED},
		'{ACT_ALL_OFF,  8'h7F, 6'd5,  1'b0, UNTYPED}
	};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [2:0]  action;
	logic [7:0]  data_byte;
	logic [5:0]  device_room;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [5:0]  cfg_data;
	logic        strobe;
	logic        byte_valid;
	logic        port_select;
	logic [7:0]  out_byte;
	logic        last_of_run;
	logic        dropped;
	logic        ready_flag;
	logic [7:0]  queue_count;
	logic [31:0] bytes_sent_total;

	midi_uart_transmit_queue u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.action           (action),
		.data_byte        (data_byte),
		.device_room      (device_room),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.strobe           (strobe),
		.byte_valid       (byte_valid),
		.port_select      (port_select),
		.out_byte         (out_byte),
		.last_of_run      (last_of_run),
		.dropped          (dropped),
		.ready_flag       (ready_flag),
		.queue_count      (queue_count),
		.bytes_sent_total (bytes_sent_total)
	);

	// Our own copy of the queue and port state. The pointers are eight bits wide, so they wrap
	// at the queue depth on their own, and their difference is the fill level.
	logic [7:0]  tx_mem [QUEUE_DEPTH];
	logic [7:0]  tx_rd;
	logic [7:0]  tx_wr;
	logic        tx_ready;
	logic [31:0] tx_sent;
	logic [5:0]  tx_budget;
	int          drops_predicted;

	// Results still owed by the block, oldest first.
	port_result_t port_writes_due [$];

	int  mismatches;
	int  quiet_cycles;
	int  burst_left;
	bit  start_high;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Builds a result from the model state as it stands right now.
	function automatic port_result_t port_snapshot(logic valid, logic port, logic [7:0] value,
			logic drop);
		port_result_t r;
		r.byte_valid       = valid;
		r.port_select      = port;
		r.out_byte         = value;
		r.last_of_run      = 1'b0;
		r.dropped          = drop;
		r.ready_flag       = tx_ready;
		r.queue_count      = tx_wr - tx_rd;
		r.bytes_sent_total = tx_sent;
		return r;
	endfunction

	// Applies one accepted item to the model and returns the port writes it causes.
	task automatic predict_port_writes(input logic [2:0] act, input logic [7:0] data,
			input logic [5:0] room, output port_result_t writes [$]);
		logic [7:0] next_wr;
		logic [7:0] popped;
		int         limit;
		writes = {};
		case (act)
			ACT_SEND: begin
				// One slot always stays empty, so a full queue has the write pointer just
				// behind the read pointer.
				next_wr = tx_wr + 8'd1;
				if (next_wr != tx_rd) begin
					tx_mem[tx_wr] = data;
					tx_wr = next_wr;
					writes.push_back(port_snapshot(1'b0, 1'b0, 8'h00, 1'b0));
				end else begin
					drops_predicted++;
					writes.push_back(port_snapshot(1'b0, 1'b0, 8'h00, 1'b1));
				end
			end
			ACT_FLUSH: begin
				// The flush is bounded by the budget (saturated at its maximum), the room the
				// port reports, and the bytes actually waiting.
				limit = (tx_budget > BUDGET_MAX) ? int'(BUDGET_MAX) : int'(tx_budget);
				if (int'(room) < limit)
					limit = int'(room);
				while (limit > 0 && tx_rd != tx_wr) begin
					popped = tx_mem[tx_rd];
					tx_rd = tx_rd + 8'd1;
					tx_sent = tx_sent + 32'd1;
					writes.push_back(port_snapshot(1'b1, 1'b0, popped, 1'b0));
					limit--;
				end
				if (writes.size() == 0)
					writes.push_back(port_snapshot(1'b0, 1'b0, 8'h00, 1'b0));
			end
			ACT_ALL_OFF: begin
				for (int ch = 0; ch <= int'(LAST_CHANNEL); ch++) begin
					writes.push_back(port_snapshot(1'b1, 1'b0, CTRL_CHANGE | 8'(ch), 1'b0));
					writes.push_back(port_snapshot(1'b1, 1'b0, CTRL_ALL_OFF, 1'b0));
					writes.push_back(port_snapshot(1'b1, 1'b0, 8'h00, 1'b0));
				end
			end
			ACT_DETECT, ACT_INIT: begin
				// Init only restarts the port when it is not already up. Both results of a
				// restart already show the emptied queue and the raised ready flag.
				if (act == ACT_DETECT || !tx_ready) begin
					tx_ready = 1'b1;
					tx_rd = 8'd0;
					tx_wr = 8'd0;
					writes.push_back(port_snapshot(1'b1, 1'b1, CMD_RESET, 1'b0));
					writes.push_back(port_snapshot(1'b1, 1'b1, CMD_UART, 1'b0));
				end else begin
					writes.push_back(port_snapshot(1'b0, 1'b0, 8'h00, 1'b0));
				end
			end
			ACT_SHUTDOWN: begin
				tx_ready = 1'b0;
				writes.push_back(port_snapshot(1'b0, 1'b0, 8'h00, 1'b0));
			end
			default: begin
				writes.push_back(port_snapshot(1'b0, 1'b0, 8'h00, 1'b0));
			end
		endcase
		writes[writes.size() - 1].last_of_run = 1'b1;
	endtask

	task automatic report_mismatch(input string what, input port_result_t want,
			input port_result_t seen);
		if (mismatches < 10) begin
			$display("%0t: %s", $realtime, what);
			$display("  expected valid=%0b port=%0b byte=%02h last=%0b drop=%0b",
				want.byte_valid, want.port_select, want.out_byte, want.last_of_run,
				want.dropped, " ready=%0b cnt=%0d sent=%0d",
				want.ready_flag, want.queue_count, want.bytes_sent_total);
			$display("  actual   valid=%0b port=%0b byte=%02h last=%0b drop=%0b",
				seen.byte_valid, seen.port_select, seen.out_byte, seen.last_of_run,
				seen.dropped, " ready=%0b cnt=%0d sent=%0d",
				seen.ready_flag, seen.queue_count, seen.bytes_sent_total);
		end
		mismatches++;
	endtask

	// Result monitor. A result is on the ports for one cycle and is taken at the edge that ends
	// that cycle, so the values read here, before this edge's updates land, are the ones that
	// belong to the strobe.
	always @(posedge clk) begin
		port_result_t seen;
		port_result_t want;
		if (arst_n === 1'b1 && strobe === 1'b1) begin
			seen = {byte_valid, port_select, out_byte, last_of_run, dropped, ready_flag,
				queue_count, bytes_sent_total};
			if (port_writes_due.size() == 0) begin
				report_mismatch("result with no item waiting for it", UNTYPED, seen);
			end else begin
				want = port_writes_due.pop_front();
				if (seen !== want)
					report_mismatch("result differs from the expected one", want, seen);
			end
		end
	end

	// Watchdog: any transfer on any channel counts as progress.
	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || strobe === 1'b1
				|| (cfg_valid === 1'b1 && cfg_ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired after %0d cycles without a transfer", quiet_cycles);
			$display("tb_midi_uart_transmit_queue failed");
			$finish;
		end
	end

	// Sender pacing: bursts of back-to-back items of random length, separated by random gaps.
	// While start is low the payload ports carry noise, which the block has to ignore.
	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 8);
			burst_left = $urandom_range(0, 15);
			start <= 1'b0;
			start_high = 1'b0;
			data_byte <= 8'($urandom);
			device_room <= 6'($urandom);
			repeat (gap) @(posedge clk);
		end
	endtask

	// Presents one item and holds it until the block takes it. On return we sit at the
	// accepting edge, so the next item (or the end of the burst) can be driven right away
	// without ever lowering start between two back-to-back transfers.
	task automatic run_item(input logic [2:0] act, input logic [7:0] data,
			input logic [5:0] room, input logic typed, input port_result_t first);
		port_result_t writes [$];
		start <= 1'b1;
		start_high = 1'b1;
		action <= act;
		data_byte <= data;
		device_room <= room;
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
		predict_port_writes(act, data, room, writes);
		if (typed)
			writes[0] = first;
		foreach (writes[i])
			port_writes_due.push_back(writes[i]);
		pace_sender();
	endtask

	// Lowers start and waits for every owed result and for busy to drop.
	task automatic settle();
		if (start_high) begin
			start <= 1'b0;
			start_high = 1'b0;
		end
		while (port_writes_due.size() != 0 || busy !== 1'b0) @(posedge clk);
	endtask

	// Register writes happen only with the block idle, and the model picks up the new budget
	// at the edge of the transfer.
	task automatic write_budget(input logic [5:0] value);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (cfg_ready !== 1'b1) @(posedge clk);
		tx_budget = value;
		cfg_valid <= 1'b0;
		cfg_data <= 6'($urandom);
	endtask

	// Draws one random item. Mixed traffic leans on sends and flushes so the queue moves
	// both ways; the fill mode is almost all sends so the queue reaches its full point; the
	// drain mode is flushes with plenty of room.
	task automatic pick_item(input stim_mode_t mode, output logic [2:0] act,
			output logic [7:0] data, output logic [5:0] room);
		int pick;
		int room_pick;
		pick = $urandom_range(0, 99);
		data = 8'($urandom);
		room = 6'($urandom);
		case (mode)
			MODE_FILL: begin
				if (pick < 96)
					act = ACT_SEND;
				else if (pick < 98)
					act = ACT_SHUTDOWN;
				else
					act = ACT_RSVD_B;
			end
			MODE_DRAIN: begin
				act = ACT_FLUSH;
				room = 6'($urandom_range(16, 63));
			end
			default: begin
				if (pick < 45) begin
					act = ACT_SEND;
				end else if (pick < 70) begin
					act = ACT_FLUSH;
					room_pick = $urandom_range(0, 9);
					if (room_pick == 0)
						room = 6'd0;
					else if (room_pick == 1)
						room = 6'($urandom_range(33, 63));
					else
						room = 6'($urandom_range(1, 32));
				end else if (pick < 75) begin
					act = ACT_ALL_OFF;
				end else if (pick < 80) begin
					act = ACT_DETECT;
				end else if (pick < 88) begin
					act = ACT_INIT;
				end else if (pick < 95) begin
					act = ACT_SHUTDOWN;
				end else begin
					act = (pick % 2 == 0) ? ACT_RSVD_A : ACT_RSVD_B;
				end
			end
		endcase
	endtask

	task automatic run_mixed(input int count);
		logic [2:0] act;
		logic [7:0] data;
		logic [5:0] room;
		repeat (count) begin
			pick_item(MODE_MIX, act, data, room);
			run_item(act, data, room, 1'b0, UNTYPED);
		end
	endtask

	initial begin
		logic [2:0] act;
		logic [7:0] data;
		logic [5:0] room;
		int         drops_base;

		mismatches = 0;
		quiet_cycles = 0;
		burst_left = 0;
		start_high = 1'b0;
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= ACT_SEND;
		data_byte <= 8'h00;
		device_room <= 6'd0;
		cfg_valid <= 1'b0;
		cfg_data <= 6'd0;

		// The model comes up the way the block leaves reset: empty queue, port down,
		// nothing sent, full budget.
		tx_rd = 8'd0;
		tx_wr = 8'd0;
		tx_ready = 1'b0;
		tx_sent = 32'd0;
		tx_budget = BUDGET_RESET;
		drops_predicted = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, at the reset budget.
		for (int i = 0; i < DIRECTED_ROWS; i++)
			run_item(DIRECTED[i].act, DIRECTED[i].data, DIRECTED[i].room, DIRECTED[i].typed,
				DIRECTED[i].first);

		// Smallest useful budget, then a budget of zero where no flush may send anything.
		write_budget(6'd1);
		run_mixed(8);
		write_budget(6'd0);
		run_mixed(4);

		// All budget bits set: the block must saturate it to the maximum.
		write_budget(6'd63);
		run_mixed(8);

		// Fill the queue until sends start getting dropped, then drain it. This also walks
		// both pointers around the end of the ring.
		write_budget(BUDGET_MAX);
		drops_base = drops_predicted;
		while (drops_predicted < drops_base + 4) begin
			pick_item(MODE_FILL, act, data, room);
			run_item(act, data, room, 1'b0, UNTYPED);
		end
		while (tx_wr != tx_rd) begin
			pick_item(MODE_DRAIN, act, data, room);
			run_item(act, data, room, 1'b0, UNTYPED);
		end

		// Just above the maximum, then an ordinary budget in between.
		write_budget(6'd33);
		run_mixed(8);
		write_budget(6'($urandom_range(2, 31)));
		run_mixed(8);

		// Let the last item finish, then give stray results time to show up.
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && port_writes_due.size() == 0) begin
			$display("tb_midi_uart_transmit_queue passed");
		end else begin
			$display("tb_midi_uart_transmit_queue failed");
		end
		$finish;
	end

endmodule
